@@ hdl/imuoc_pkg.sv @@
// Shared types, constants and helpers for the IMU offset calibration block.
`timescale 1ns / 1ps
package imuoc_pkg;

    localparam int SUM_WIDTH  = 34;
    localparam int MAG_W      = SUM_WIDTH + 1;
    localparam int CALC_W     = MAG_W + 1;
    localparam int CNT_W      = 17;
    localparam int NAXES      = 6;
    localparam int DIVISOR_W  = 16;

    localparam logic [2:0] CFG_WINDOW_LENGTH  = 3'd0;
    localparam logic [2:0] CFG_DISCARD_COUNT  = 3'd1;
    localparam logic [2:0] CFG_ACCEL_DEADZONE = 3'd2;
    localparam logic [2:0] CFG_GYRO_DEADZONE  = 3'd3;
    localparam logic [2:0] CFG_GRAVITY_COUNTS = 3'd4;

    localparam logic [2:0] AXIS_ACCEL_Z = 3'd2;
    localparam logic [2:0] AXIS_GYRO_X  = 3'd3;
    localparam logic [2:0] AXIS_LAST    = 3'd5;
    localparam logic [5:0] ALL_WITHIN   = 6'h3F;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST,
        PH_REFINE,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_DIV1,
        ST_WAIT1,
        ST_CALC,
        ST_WAIT2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               action;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] offset_accel_x;
        logic signed [15:0] offset_accel_y;
        logic signed [15:0] offset_accel_z;
        logic signed [15:0] offset_gyro_x;
        logic signed [15:0] offset_gyro_y;
        logic signed [15:0] offset_gyro_z;
        logic [5:0]         axes_within;
        logic               calibration_done;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic [MAG_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
    } t_div_rsp;

    // Clamp a wide signed value to 16 bits.
    function automatic logic signed [15:0] sat16(logic signed [CALC_W-1:0] v);
        if (v > $signed(CALC_W'(32767))) begin
            return 16'sh7FFF;
        end else if (v < -$signed(CALC_W'(32768))) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

endpackage

@@ hdl/imuoc_div.sv @@
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
module imuoc_div
    import imuoc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CW = $clog2(MAG_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [MAG_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic [DIVISOR_W:0]   n_shift;
    logic                 n_ge;
    logic [DIVISOR_W:0]   n_rem;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        n_shift = {r_rem, r_quo[MAG_W-1]};
        n_ge    = n_shift >= {1'b0, r_div};
        n_rem   = n_ge ? (n_shift - {1'b0, r_div}) : n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[MAG_W-2:0], n_ge};
                r_rem <= n_rem[DIVISOR_W-1:0];
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ hdl/imu_offset_auto_calibration_top.sv @@
// Top level: window accumulation, offset sequencer and result register.
// Samples are taken one per cycle while a window fills. At the end of a window the
// sequencer walks the six axes through one shared bit-serial divider: the mean takes
// one division, and in a refining window each axis outside its deadzone takes a
// second. A window end holds the input until every axis is done and the result has
// been loaded into the output register.
// Results leave through an output register; a new window end waits only if that
// register still holds an untaken result.
`timescale 1ns / 1ps
module imu_offset_auto_calibration_top
    import imuoc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers
    logic [15:0] r_wlen;
    logic [9:0]  r_discard;
    logic [7:0]  r_adz;
    logic [7:0]  r_gdz;
    logic [14:0] r_grav;

    t_state r_state, n_state;
    t_phase r_phase;

    logic signed [SUM_WIDTH-1:0] r_sum [NAXES];
    logic signed [15:0]          r_off [NAXES];
    logic [CNT_W-1:0]            r_cnt;
    logic [2:0]                  r_axis;
    logic [5:0]                  r_within;
    logic signed [MAG_W-1:0]     r_mean;
    logic                        r_eneg;
    logic                        r_out_valid;
    t_out_item                   r_out_item;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                        in_acc;
    logic [CNT_W-1:0]            len;
    logic [CNT_W-1:0]            last;
    logic signed [15:0]          smp [NAXES];
    logic signed [SUM_WIDTH-1:0] cur_sum;
    logic [SUM_WIDTH-1:0]        sum_mag;
    logic signed [MAG_W-1:0]     grav_ext;
    logic signed [MAG_W-1:0]     e_val;
    logic                        e_neg;
    logic [MAG_W-1:0]            e_mag;
    logic                        is_accel;
    logic [7:0]                  dz;
    logic                        ax_within;
    logic [DIVISOR_W-1:0]        div2;
    logic [MAG_W-1:0]            first_sh;
    logic signed [CALC_W-1:0]    first_val;
    logic signed [CALC_W-1:0]    q2s;
    logic signed [CALC_W-1:0]    refine_val;
    logic                        out_free;

    imuoc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_ACC);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Window bounds
    always_comb begin
        len  = (r_wlen == 16'd0) ? CNT_W'(1) : CNT_W'(r_wlen);
        last = CNT_W'(r_discard) + len - CNT_W'(1);
    end

    assign smp[0] = i_in_item.accel_x;
    assign smp[1] = i_in_item.accel_y;
    assign smp[2] = i_in_item.accel_z;
    assign smp[3] = i_in_item.gyro_x;
    assign smp[4] = i_in_item.gyro_y;
    assign smp[5] = i_in_item.gyro_z;

    // Per-axis arithmetic for the axis under work
    always_comb begin
        cur_sum   = r_sum[r_axis];
        sum_mag   = cur_sum[SUM_WIDTH-1] ? SUM_WIDTH'(-cur_sum) : SUM_WIDTH'(cur_sum);
        grav_ext  = $signed({{(MAG_W-15){1'b0}}, r_grav});
        e_val     = (r_axis == AXIS_ACCEL_Z) ? (r_mean - grav_ext) : r_mean;
        e_neg     = e_val[MAG_W-1];
        e_mag     = e_neg ? MAG_W'(-e_val) : MAG_W'(e_val);
        is_accel  = (r_axis < AXIS_GYRO_X);
        dz        = is_accel ? r_adz : r_gdz;
        ax_within = (e_mag <= MAG_W'(dz));
        if (is_accel) begin
            div2 = (r_adz == 8'd0) ? DIVISOR_W'(1) : DIVISOR_W'(r_adz);
        end else begin
            div2 = DIVISOR_W'(r_gdz) + DIVISOR_W'(1);
        end
        first_sh   = is_accel ? (e_mag >> 3) : (e_mag >> 2);
        first_val  = e_neg ? $signed({1'b0, first_sh}) : -$signed({1'b0, first_sh});
        q2s        = r_eneg ? -$signed({1'b0, div_rsp.quotient})
                            : $signed({1'b0, div_rsp.quotient});
        refine_val = CALC_W'(r_off[r_axis]) - q2s;
    end

    // Next state and divider requests
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, sum_mag};
        div_req.divisor  = r_wlen == 16'd0 ? DIVISOR_W'(1) : r_wlen;
        case (r_state)
            ST_ACC: begin
                if (in_acc && !i_in_item.action &&
                    (r_phase == PH_FIRST || r_phase == PH_REFINE) && !(r_cnt < last)) begin
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1: begin
                div_req.start = 1'b1;
                n_state       = ST_WAIT1;
            end
            ST_WAIT1: begin
                if (div_rsp.done) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (r_phase == PH_REFINE && !ax_within) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = e_mag;
                    div_req.divisor  = div2;
                    n_state          = ST_WAIT2;
                end else begin
                    n_state = (r_axis == AXIS_LAST) ? ST_OUT : ST_DIV1;
                end
            end
            ST_WAIT2: begin
                if (div_rsp.done) begin
                    n_state = (r_axis == AXIS_LAST) ? ST_OUT : ST_DIV1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_ACC;
                end
            end
            default: n_state = ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen    <= 16'd1000;
            r_discard <= 10'd101;
            r_adz     <= 8'd8;
            r_gdz     <= 8'd1;
            r_grav    <= 15'd16384;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH:  r_wlen    <= i_cfg_data;
                CFG_DISCARD_COUNT:  r_discard <= i_cfg_data[9:0];
                CFG_ACCEL_DEADZONE: r_adz     <= i_cfg_data[7:0];
                CFG_GYRO_DEADZONE:  r_gdz     <= i_cfg_data[7:0];
                CFG_GRAVITY_COUNTS: r_grav    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Accumulate, sequence the axes and load results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_axis      <= '0;
            r_within    <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NAXES; i++) begin
                r_sum[i] <= '0;
                r_off[i] <= '0;
            end
        end else begin
            // Load a new result, or drop the one just taken
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_ACC: begin
                    if (in_acc) begin
                        if (i_in_item.action) begin
                            // start: zero everything and open the first window
                            r_cnt   <= '0;
                            r_phase <= PH_FIRST;
                            for (int i = 0; i < NAXES; i++) begin
                                r_sum[i] <= '0;
                                r_off[i] <= '0;
                            end
                        end else if (r_phase == PH_FIRST || r_phase == PH_REFINE) begin
                            if (r_cnt >= CNT_W'(r_discard) && r_cnt <= last) begin
                                for (int i = 0; i < NAXES; i++) begin
                                    r_sum[i] <= r_sum[i] + SUM_WIDTH'(smp[i]);
                                end
                            end
                            if (r_cnt < last) begin
                                r_cnt <= r_cnt + CNT_W'(1);
                            end else begin
                                r_axis   <= '0;
                                r_within <= '0;
                            end
                        end
                    end
                end
                ST_WAIT1: begin
                    if (div_rsp.done) begin
                        r_mean <= cur_sum[SUM_WIDTH-1] ? -$signed(div_rsp.quotient)
                                                       : $signed(div_rsp.quotient);
                    end
                end
                ST_CALC: begin
                    r_eneg <= e_neg;
                    if (r_phase == PH_FIRST) begin
                        r_off[r_axis] <= sat16(first_val);
                    end else if (ax_within) begin
                        r_within[r_axis] <= 1'b1;
                    end
                    if (r_phase == PH_FIRST || ax_within) begin
                        r_axis <= r_axis + 3'd1;
                    end
                end
                ST_WAIT2: begin
                    if (div_rsp.done) begin
                        r_off[r_axis] <= sat16(refine_val);
                        r_axis        <= r_axis + 3'd1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_item.offset_accel_x   <= r_off[0];
                        r_out_item.offset_accel_y   <= r_off[1];
                        r_out_item.offset_accel_z   <= r_off[2];
                        r_out_item.offset_gyro_x    <= r_off[3];
                        r_out_item.offset_gyro_y    <= r_off[4];
                        r_out_item.offset_gyro_z    <= r_off[5];
                        r_out_item.axes_within      <= r_within;
                        r_out_item.calibration_done <= (r_within == ALL_WITHIN);
                        if (r_phase == PH_FIRST) begin
                            r_phase <= PH_REFINE;
                        end else if (r_within == ALL_WITHIN) begin
                            r_phase <= PH_DONE;
                        end
                        r_cnt <= '0;
                        for (int i = 0; i < NAXES; i++) begin
                            r_sum[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/imuoc_checker.sv @@
// Port-level checker for the IMU offset calibration block, with its bind.
`timescale 1ns / 1ps
module imuoc_checker
    import imuoc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result changed");

    // Done only with every axis inside its deadzone
    a_done_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.calibration_done |-> o_out_item.axes_within == ALL_WITHIN)
        else $error("done without all axes within");

    // A start item never causes a result
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.action |=> !$rose(o_out_valid))
        else $error("result after start item");

endmodule

bind imu_offset_auto_calibration_top imuoc_checker u_imuoc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ bench/imu_offset_auto_calibration_top_tb.sv @@
// Testbench for the IMU offset calibration block: directed table, random windows, self-check.
`timescale 1ns / 1ps
module imu_offset_auto_calibration_top_tb;
    import imuoc_pkg::*;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_START  = 1'b1;
    localparam int   SETTLE_CYCLES = 500;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    imu_offset_auto_calibration_top DUT (.*);

    // Calibration shadow state
    int unsigned win_len, discard_n, accel_dz, gyro_dz, grav_cnt;
    longint      sums [NAXES];
    int unsigned win_count;
    longint      offsets [NAXES];
    t_phase      phase;

    t_out_item   offsets_pending[$];
    int          err_count;
    int          items_sent;
    int          windows_seen;
    int          done_seen;
    int          holdoff_req;
    bit          quiet;

    // Clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Run limit
    initial begin
        #50ms;
        $display("Timeout while waiting for the block");
        $display("Some tests failed");
        $finish;
    end

    function automatic longint wrap_sum(longint v);
        return (v <<< (64 - SUM_WIDTH)) >>> (64 - SUM_WIDTH);
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the calibration state by one accepted item
    task automatic calibrate_step(input t_in_item it);
        int unsigned len, last;
        longint      mean [NAXES];
        longint      raw [NAXES];
        longint      grav, adiv, gdiv, dz;
        logic [5:0]  in_zone;
        t_out_item   res;
        in_zone = '0;
        raw[0] = it.accel_x; raw[1] = it.accel_y; raw[2] = it.accel_z;
        raw[3] = it.gyro_x;  raw[4] = it.gyro_y;  raw[5] = it.gyro_z;
        if (it.action == ACT_START) begin
            foreach (sums[i]) begin
                sums[i] = 0;
                offsets[i] = 0;
            end
            win_count = 0;
            phase = PH_FIRST;
            return;
        end
        if (phase != PH_FIRST && phase != PH_REFINE) return;
        len  = (win_len == 0) ? 1 : win_len;
        last = discard_n + len - 1;
        if (win_count >= discard_n && win_count <= last) begin
            foreach (sums[i]) sums[i] = wrap_sum(sums[i] + raw[i]);
        end
        if (win_count < last) begin
            win_count = (win_count + 1) & 32'h1FFFF;
            return;
        end
        grav = grav_cnt;
        adiv = (accel_dz == 0) ? 1 : accel_dz;
        gdiv = gyro_dz + 1;
        foreach (mean[i]) mean[i] = sums[i] / longint'(len);
        if (phase == PH_FIRST) begin
            offsets[0] = clamp16(-mean[0] / 8);
            offsets[1] = clamp16(-mean[1] / 8);
            offsets[2] = clamp16((grav - mean[2]) / 8);
            for (int i = 3; i < NAXES; i++) offsets[i] = clamp16(-mean[i] / 4);
            phase = PH_REFINE;
        end else begin
            for (int i = 0; i < NAXES; i++) begin
                dz = (i < 3) ? accel_dz : gyro_dz;
                if (i == 2) begin
                    if (absval(grav - mean[2]) <= dz) in_zone[2] = 1'b1;
                    else offsets[2] = clamp16(offsets[2] + (grav - mean[2]) / adiv);
                end else if (absval(mean[i]) <= dz) begin
                    in_zone[i] = 1'b1;
                end else begin
                    offsets[i] = clamp16(offsets[i] - mean[i] / ((i < 3) ? adiv : gdiv));
                end
            end
            if (in_zone == ALL_WITHIN) phase = PH_DONE;
        end
        foreach (sums[i]) sums[i] = 0;
        win_count = 0;
        res.offset_accel_x   = offsets[0];
        res.offset_accel_y   = offsets[1];
        res.offset_accel_z   = offsets[2];
        res.offset_gyro_x    = offsets[3];
        res.offset_gyro_y    = offsets[4];
        res.offset_gyro_z    = offsets[5];
        res.axes_within      = in_zone;
        res.calibration_done = (in_zone == ALL_WITHIN);
        offsets_pending.push_back(res);
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // Check each taken result against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            windows_seen++;
            if (o_out_item.calibration_done) done_seen++;
            if (offsets_pending.size() == 0) begin
                report_mismatch("result with no expectation");
            end else begin
                want = offsets_pending.pop_front();
                for (int i = 0; i < NAXES; i++) begin
                    if (o_out_item[102-16*i -: 16] !== want[102-16*i -: 16])
                        report_mismatch($sformatf("axis %0d offset got %0d want %0d", i,
                            $signed(o_out_item[102-16*i -: 16]),
                            $signed(want[102-16*i -: 16])));
                end
                if (o_out_item.axes_within !== want.axes_within)
                    report_mismatch($sformatf("axes_within got %h want %h",
                        o_out_item.axes_within, want.axes_within));
                if (o_out_item.calibration_done !== want.calibration_done)
                    report_mismatch("calibration_done differs");
            end
        end
    end

    // Drive receiver stall: random, quiet stretches, and one long hold-off on request
    always @(negedge i_clk) begin
        int r;
        if (holdoff_req > 0) begin
            i_out_stall <= 1'b1;
            holdoff_req <= holdoff_req - 1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            r = $urandom_range(99);
            i_out_stall <= (r < 25) || (r > 97);
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one item, hold it until taken, then idle a random gap
    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_item  = it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        calibrate_step(it);
        items_sent++;
        repeat (pick_gap()) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_in_valid  = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val[15:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_WINDOW_LENGTH:  win_len   = val & 16'hFFFF;
            CFG_DISCARD_COUNT:  discard_n = val & 10'h3FF;
            CFG_ACCEL_DEADZONE: accel_dz  = val & 8'hFF;
            CFG_GYRO_DEADZONE:  gyro_dz   = val & 8'hFF;
            CFG_GRAVITY_COUNTS: grav_cnt  = val & 15'h7FFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Wait for all expected results, then let any window-end work finish
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (offsets_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(logic act, int ax, int ay, int az,
                                           int gx, int gy, int gz);
        t_in_item it;
        it.action = act;
        it.accel_x = ax; it.accel_y = ay; it.accel_z = az;
        it.gyro_x  = gx; it.gyro_y  = gy; it.gyro_z  = gz;
        return it;
    endfunction

    function automatic int noise(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    // Sample near rest (mostly), or anywhere in the field range; now and then a start item
    function automatic t_in_item random_item();
        int r;
        r = $urandom_range(99);
        if (r < 3) return make_item(ACT_START, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom);
        if (r < 75) return make_item(ACT_SAMPLE,
            noise(2 * accel_dz + 2), noise(2 * accel_dz + 2),
            grav_cnt + noise(2 * accel_dz + 2),
            noise(2 * gyro_dz + 2), noise(2 * gyro_dz + 2), noise(2 * gyro_dz + 2));
        if (r < 90) return make_item(ACT_SAMPLE, noise(3000), noise(3000),
            noise(32767), noise(3000), noise(3000), noise(3000));
        return make_item(ACT_SAMPLE, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom);
    endfunction

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_row;

    t_row rows[$];

    initial begin
        t_row      row;
        t_out_item typed_res;
        int        phase_idx;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WINDOW_LENGTH;
        i_cfg_data  = '0;
        err_count = 0; items_sent = 0; windows_seen = 0; done_seen = 0;
        holdoff_req = 0; quiet = 1'b0;
        win_len = 1000; discard_n = 101; accel_dz = 8; gyro_dz = 1; grav_cnt = 16384;
        foreach (sums[i]) begin
            sums[i] = 0;
            offsets[i] = 0;
        end
        win_count = 0;
        phase = PH_IDLE;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: one-sample windows, no discard
        write_reg(CFG_WINDOW_LENGTH, 1);
        write_reg(CFG_DISCARD_COUNT, 0);
        rows.push_back('{make_item(ACT_SAMPLE, 5, 5, 5, 5, 5, 5), 0, '0});
        rows.push_back('{make_item(ACT_START, -1, -1, -1, -1, -1, -1), 0, '0});
        typed_res = '0;
        typed_res.offset_accel_z = 16'sd2048;
        rows.push_back('{make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0), 1, typed_res});
        typed_res.offset_accel_z = 16'sd4096;
        typed_res.axes_within = 6'h3B;
        rows.push_back('{make_item(ACT_SAMPLE, 0, 0, 0, 0, 0, 0), 1, typed_res});
        rows.push_back('{make_item(ACT_SAMPLE, 32767, 32767, 32767, 32767, 32767, 32767),
                         0, '0});
        rows.push_back('{make_item(ACT_SAMPLE, -32768, -32768, -32768, -32768, -32768,
                         -32768), 0, '0});
        rows.push_back('{make_item(ACT_SAMPLE, -32768, -32768, -32768, -32768, -32768,
                         -32768), 0, '0});
        rows.push_back('{make_item(ACT_START, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(ACT_SAMPLE, 32767, -32768, -32768, 32767, -32768,
                         32767), 0, '0});
        rows.push_back('{make_item(ACT_SAMPLE, 3, -4, 16390, 1, -1, 0), 0, '0});
        rows.push_back('{make_item(ACT_SAMPLE, 0, 0, 16384, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(ACT_SAMPLE, 0, 0, 16384, 0, 0, 0), 0, '0});
        rows.push_back('{make_item(ACT_SAMPLE, 100, 100, 100, 100, 100, 100), 0, '0});
        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.item);
            if (row.typed) begin
                // typed value stands in for the predicted one
                void'(offsets_pending.pop_back());
                offsets_pending.push_back(row.result);
            end
        end
        drain();

        // Largest window, then shrink it mid-window: the next sample closes it
        write_reg(CFG_WINDOW_LENGTH, 65535);
        write_reg(CFG_DISCARD_COUNT, 1023);
        write_reg(CFG_ACCEL_DEADZONE, 255);
        write_reg(CFG_GYRO_DEADZONE, 255);
        write_reg(CFG_GRAVITY_COUNTS, 32767);
        send_item(make_item(ACT_START, 0, 0, 0, 0, 0, 0));
        repeat (6) send_item(random_item());
        drain();
        write_reg(CFG_WINDOW_LENGTH, 0);
        write_reg(CFG_DISCARD_COUNT, 0);
        write_reg(CFG_ACCEL_DEADZONE, 0);
        write_reg(CFG_GYRO_DEADZONE, 0);
        write_reg(CFG_GRAVITY_COUNTS, 0);
        repeat (4) send_item(random_item());
        drain();

        // Random phases with fresh settings each time
        phase_idx = 0;
        while (items_sent < 2100) begin
            write_reg(CFG_WINDOW_LENGTH, $urandom_range(6, 1));
            write_reg(CFG_DISCARD_COUNT, $urandom_range(3));
            write_reg(CFG_ACCEL_DEADZONE, ($urandom_range(9) == 0) ? 0 : $urandom_range(255));
            write_reg(CFG_GYRO_DEADZONE, $urandom_range(255));
            write_reg(CFG_GRAVITY_COUNTS, $urandom_range(32767));
            quiet = (phase_idx % 4 == 3);
            if (phase_idx == 1) holdoff_req = 3000;
            send_item(make_item(ACT_START, 0, 0, 0, 0, 0, 0));
            repeat (250) send_item(random_item());
            drain();
            phase_idx++;
        end

        drain();
        $display("Covered %0d items over %0d phases; %0d windows checked, %0d done.",
                 items_sent, phase_idx + 3, windows_seen, done_seen);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
